FILE: sv/multichannel_spike_counter_defines.svh
// ----------------------------------------------------------------------------
// Multichannel spike counter: assertion macros
// Shared assertion shorthands, clocked on clk_i and muted while in reset.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_SPIKE_COUNTER_DEFINES_SVH
`define MULTICHANNEL_SPIKE_COUNTER_DEFINES_SVH

// Check that a property holds at every clock edge out of reset
`define MSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define MSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/msc_pkg.sv
// ----------------------------------------------------------------------------
// Multichannel spike counter package
// Field widths, function codes and the per-channel state entry layout.
// ----------------------------------------------------------------------------
package msc_pkg;

  // Channel count default
  localparam int unsigned DefaultChannels = 512;

  // Transaction field widths
  localparam int unsigned FuncW    = 2;
  localparam int unsigned ChanW    = 9;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned RunLenW  = 8;
  localparam int unsigned RunW     = 9;
  localparam int unsigned CountW   = 32;

  // Reset value of the run length register
  localparam logic [RunLenW-1:0] RunLenReset = RunLenW'(1);

  // Depth of the result holding queue
  localparam int unsigned ResDepth = 3;

  // Function codes of an input transaction
  typedef enum logic [FuncW-1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_WR_THR = 2'd1,
    FUNC_RD_CNT = 2'd2
  } func_e;

  // One channel's state as held in memory
  typedef struct packed {
    logic signed [SampleW-1:0] thr;
    logic [RunW-1:0]           run;
    logic [CountW-1:0]         cnt;
  } entry_t;

endpackage

FILE: sv/msc_in_if.sv
// ----------------------------------------------------------------------------
// Multichannel spike counter input channel
// Valid/ready channel carrying sample, threshold and read transactions.
// ----------------------------------------------------------------------------
interface msc_in_if;
  import msc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [FuncW-1:0]          func;
  logic [ChanW-1:0]          channel;
  logic signed [SampleW-1:0] sample_value;
  logic                      first_of_block;
  logic signed [SampleW-1:0] threshold_word;

  modport source (
    output valid, func, channel, sample_value, first_of_block, threshold_word,
    input  ready
  );

  modport sink (
    input  valid, func, channel, sample_value, first_of_block, threshold_word,
    output ready
  );
endinterface

FILE: sv/msc_out_if.sv
// ----------------------------------------------------------------------------
// Multichannel spike counter result channel
// Valid/ready channel carrying a channel number and its spike total.
// ----------------------------------------------------------------------------
interface msc_out_if;
  import msc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ChanW-1:0]  out_channel;
  logic [CountW-1:0] spike_total;

  modport source (
    output valid, out_channel, spike_total,
    input  ready
  );

  modport sink (
    input  valid, out_channel, spike_total,
    output ready
  );
endinterface

FILE: sv/msc_cfg_if.sv
// ----------------------------------------------------------------------------
// Multichannel spike counter configuration channel
// Valid/ready write channel for the run length register.
// ----------------------------------------------------------------------------
interface msc_cfg_if;
  import msc_pkg::*;

  logic               valid;
  logic               ready;
  logic [RunLenW-1:0] run_length;

  modport source (
    output valid, run_length,
    input  ready
  );

  modport sink (
    input  valid, run_length,
    output ready
  );
endinterface

FILE: sv/multichannel_spike_counter.sv
// ----------------------------------------------------------------------------
// Multichannel spike counter
// Per-channel threshold-crossing spike counting with software read and clear.
// ----------------------------------------------------------------------------
// The block takes one transaction per cycle while item_i.ready is high. Each
// one passes a two-stage read-modify-write pipeline over a single state memory
// of CHANNELS entries (threshold, run counter, spike count): the entry is read
// at acceptance and written back in the cycle after, with the last write
// forwarded to a directly following transaction on the same channel. A count
// read presents its result through a three-entry holding queue, into which it
// is registered from stage one; input is paused only while that queue and the
// pipeline could not absorb another result. After reset a clearing pass zeroes
// every entry of the memory, during which no input transaction is taken;
// configuration writes are taken at any time.
module multichannel_spike_counter #(
  parameter int unsigned CHANNELS = msc_pkg::DefaultChannels
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  msc_cfg_if.sink   cfg_i,
  msc_in_if.sink    item_i,
  msc_out_if.source result_o
);
  import msc_pkg::*;

  `include "multichannel_spike_counter_defines.svh"

  localparam int unsigned IdxW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned ExtW  = (IdxW > ChanW) ? IdxW : ChanW;
  localparam int unsigned ChkW  = ExtW + 1;
  localparam int unsigned PtrW  = $clog2(ResDepth);
  localparam int unsigned OccW  = $clog2(ResDepth + 1);

  // Run length register
  logic [RunLenW-1:0] run_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_len_q <= RunLenReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      run_len_q <= cfg_i.run_length;
    end
  end

  assign cfg_i.ready = 1'b1;

  // Clearing pass after reset
  logic            clr_busy_q;
  logic [IdxW-1:0] clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_idx_q == IdxW'(CHANNELS - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_idx_q <= clr_idx_q + IdxW'(1);
    end
  end

  // Input decode
  logic [ExtW-1:0] in_chan_ext;
  logic [IdxW-1:0] in_idx;
  logic            in_chan_ok;
  logic            in_accept;

  assign in_chan_ext = ExtW'(item_i.channel);
  assign in_idx      = in_chan_ext[IdxW-1:0];
  assign in_chan_ok  = ChkW'(item_i.channel) < ChkW'(CHANNELS);
  assign in_accept   = item_i.valid && item_i.ready;

  // Stage one: transaction waiting on its memory read
  logic                      s1_valid_q;
  logic [FuncW-1:0]          s1_func_q;
  logic [ChanW-1:0]          s1_chan_q;
  logic [IdxW-1:0]           s1_idx_q;
  logic                      s1_chan_ok_q;
  logic signed [SampleW-1:0] s1_sample_q;
  logic                      s1_first_q;
  logic signed [SampleW-1:0] s1_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q    <= item_i.func;
      s1_chan_q    <= item_i.channel;
      s1_idx_q     <= in_idx;
      s1_chan_ok_q <= in_chan_ok;
      s1_sample_q  <= item_i.sample_value;
      s1_first_q   <= item_i.first_of_block;
      s1_thr_q     <= item_i.threshold_word;
    end
  end

  // State memory
  entry_t          mem_q [CHANNELS];
  entry_t          rd_data_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  entry_t          mem_wdata;
  entry_t          new_entry;
  logic            wr_en;

  assign mem_we    = clr_busy_q || wr_en;
  assign mem_waddr = clr_busy_q ? clr_idx_q : s1_idx_q;
  assign mem_wdata = clr_busy_q ? entry_t'('0) : new_entry;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[in_idx];
  end

  // Last write, forwarded to a transaction that read the same entry alongside it
  logic            wb_valid_q;
  logic [IdxW-1:0] wb_idx_q;
  entry_t          wb_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_valid_q <= 1'b0;
    end else begin
      wb_valid_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wb_idx_q  <= s1_idx_q;
      wb_data_q <= new_entry;
    end
  end

  // Modify the entry
  entry_t          cur;
  logic            low;
  logic [RunW:0]   run_inc;
  logic [RunW-1:0] run_lim;
  logic [RunW-1:0] run_sat;
  logic            res_push;
  logic [CountW-1:0] res_total;

  always_comb begin
    cur       = (wb_valid_q && (wb_idx_q == s1_idx_q)) ? wb_data_q : rd_data_q;
    low       = s1_sample_q <= cur.thr;
    run_inc   = {1'b0, cur.run} + (RunW + 1)'(1);
    run_lim   = {1'b0, run_len_q} + RunW'(1);
    run_sat   = (run_inc > {1'b0, run_lim}) ? run_lim : run_inc[RunW-1:0];
    new_entry = cur;
    wr_en     = 1'b0;
    res_push  = 1'b0;
    res_total = '0;
    if (s1_valid_q) begin
      unique case (s1_func_q)
        FUNC_SAMPLE: begin
          wr_en = s1_chan_ok_q;
          if (s1_first_q) begin
            new_entry.run = low ? {1'b0, run_len_q} : '0;
          end else if (low) begin
            new_entry.run = run_sat;
            if ((run_sat == {1'b0, run_len_q}) && (cur.cnt != '1)) begin
              new_entry.cnt = cur.cnt + CountW'(1);
            end
          end else begin
            new_entry.run = '0;
          end
        end
        FUNC_WR_THR: begin
          wr_en         = s1_chan_ok_q;
          new_entry.thr = s1_thr_q;
          new_entry.run = '0;
          new_entry.cnt = '0;
        end
        FUNC_RD_CNT: begin
          wr_en         = s1_chan_ok_q;
          new_entry.cnt = '0;
          res_push      = 1'b1;
          res_total     = s1_chan_ok_q ? cur.cnt : '0;
        end
        default: begin
          // Unused function code: drop the transaction
        end
      endcase
    end
  end

  // Result holding queue
  logic [ChanW-1:0]  res_chan_q  [ResDepth];
  logic [CountW-1:0] res_total_q [ResDepth];
  logic [PtrW-1:0]   res_wptr_q;
  logic [PtrW-1:0]   res_rptr_q;
  logic [OccW-1:0]   res_occ_q;
  logic              res_pop;
  logic              s1_rd;

  assign res_pop = result_o.valid && result_o.ready;
  assign s1_rd   = s1_valid_q && (s1_func_q == FUNC_RD_CNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wptr_q <= '0;
      res_rptr_q <= '0;
      res_occ_q  <= '0;
    end else begin
      if (res_push) begin
        res_wptr_q <= (res_wptr_q == PtrW'(ResDepth - 1)) ? '0 : res_wptr_q + PtrW'(1);
      end
      if (res_pop) begin
        res_rptr_q <= (res_rptr_q == PtrW'(ResDepth - 1)) ? '0 : res_rptr_q + PtrW'(1);
      end
      if (res_push && !res_pop) begin
        res_occ_q <= res_occ_q + OccW'(1);
      end else if (res_pop && !res_push) begin
        res_occ_q <= res_occ_q - OccW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_chan_q[res_wptr_q]  <= s1_chan_q;
      res_total_q[res_wptr_q] <= res_total;
    end
  end

  assign result_o.valid       = res_occ_q != '0;
  assign result_o.out_channel = res_chan_q[res_rptr_q];
  assign result_o.spike_total = res_total_q[res_rptr_q];

  // Hold input while clearing or while a further result might not fit
  assign item_i.ready = !clr_busy_q &&
                        ((res_occ_q + OccW'(s1_rd)) < OccW'(ResDepth));

  // Checks
  `MSC_ASSERT(a_no_accept_in_clear, !(clr_busy_q && item_i.ready),
              "input taken during clearing pass")
  `MSC_ASSERT(a_no_pipe_in_clear, !(clr_busy_q && s1_valid_q),
              "pipeline busy during clearing pass")
  `MSC_ASSERT(a_result_fits, !(res_push && !res_pop && (res_occ_q == OccW'(ResDepth))),
              "result queue overflow")
  `MSC_ASSERT_NEXT(a_result_pushed, s1_rd && !res_pop,
                   res_occ_q == $past(res_occ_q) + OccW'(1),
                   "count read produced no result")

endmodule
